// ===== rtl/cfb_pkg.sv =====
// ============================================================================
// cfb_pkg - shared types and helpers for the command frame builder
// Holds the CRC-16/MODBUS byte update and the result buffer load transfer.
// ============================================================================
package cfb_pkg;

    // CRC-16/MODBUS: reflected polynomial, all-ones start value
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Header bytes ahead of the first payload byte of a frame
    localparam int HDR_BYTES = 6;
    // Data bytes one item can place in the result buffer
    localparam int BUF_DEPTH = HDR_BYTES + 1;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // One item's worth of bytes handed to the output serializer
    typedef struct packed {
        logic [BUF_DEPTH-1:0][7:0] bytes;    // element 0 goes out first
        logic [CNT_W-1:0]          n_data;   // data bytes in use
        logic                      add_crc;  // close the frame with the CRC
    } t_load;

    // Fold one byte into the running CRC, bit by bit, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/cfb_out_buf.sv =====
// ============================================================================
// cfb_out_buf - result buffer and CRC trailer serializer
// Holds up to one item's bytes, sends them one per transfer while folding
// each into the running CRC, and closes a frame with the CRC low and high.
// ============================================================================
module cfb_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  cfb_pkg::t_load i_load_data,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_frame_end,
    output logic           o_run_last
);
    import cfb_pkg::*;

    localparam logic [1:0] CRC_BOTH = 2'd2;
    localparam logic [1:0] CRC_HIGH = 2'd1;
    localparam logic [1:0] CRC_NONE = 2'd0;

    logic [BUF_DEPTH-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]          r_data_left;
    logic [1:0]                r_crc_left;
    logic [15:0]               r_crc;

    logic w_has_data;
    logic w_busy;
    logic w_xfer;
    logic w_last;

    // Buffer status and the transfer on the result side
    assign w_has_data = (r_data_left != '0);
    assign w_busy     = w_has_data || (r_crc_left != CRC_NONE);
    assign w_xfer     = w_busy && !i_stall;
    assign w_last     = (r_data_left == CNT_W'(1) && r_crc_left == CRC_NONE)
                     || (!w_has_data && r_crc_left == CRC_HIGH);
    assign o_free     = !w_busy || (w_xfer && w_last);

    // Select the byte at the head: buffered data, then CRC low, then CRC high
    assign o_valid     = w_busy;
    assign o_out_byte  = w_has_data ? r_bytes[0]
                       : ((r_crc_left == CRC_BOTH) ? r_crc[7:0] : r_crc[15:8]);
    assign o_frame_end = !w_has_data && (r_crc_left == CRC_HIGH);
    assign o_run_last  = w_last;

    // Advance counters and CRC; a new load replaces the counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_left <= '0;
            r_crc_left  <= CRC_NONE;
            r_crc       <= CRC_INIT;
        end else begin
            if (w_xfer) begin
                if (w_has_data) begin
                    r_crc <= crc_byte(r_crc, r_bytes[0]);
                end else if (r_crc_left == CRC_HIGH) begin
                    r_crc <= CRC_INIT;
                end
            end
            if (i_load) begin
                r_data_left <= i_load_data.n_data;
                r_crc_left  <= i_load_data.add_crc ? CRC_BOTH : CRC_NONE;
            end else if (w_xfer) begin
                if (w_has_data) begin
                    r_data_left <= r_data_left - CNT_W'(1);
                end else if (r_crc_left == CRC_BOTH) begin
                    r_crc_left <= CRC_HIGH;
                end else begin
                    r_crc_left <= CRC_NONE;
                end
            end
        end
    end

    // Shift data bytes toward the head; load a new item when free
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_load_data.bytes;
        end else if (w_xfer && w_has_data) begin
            r_bytes <= {8'h00, r_bytes[BUF_DEPTH-1:1]};
        end
    end

endmodule

// ===== rtl/command_frame_builder_crc16.sv =====
// ============================================================================
// command_frame_builder_crc16 - serial command frame builder with CRC-16
// Wraps payload bytes in a header (two header bytes, command id, ack flag,
// length high and low) and closes each frame with CRC-16/MODBUS, low first.
// ============================================================================
// Each input item yields one output byte per transfer: 1 byte mid-frame, 7 on
// the first item of a frame, and 2 more CRC bytes on the item that ends the
// frame, so an item yields 1, 3, 7 or 9 bytes. The output serializer sets
// the rate: unless the receiver stalls, it sends one byte per cycle and takes
// the next item from the input register in the cycle its last byte leaves,
// so mid-frame payload bytes flow at one per cycle. The CRC is folded in one
// byte per output transfer. Header registers sit at byte addresses 0 and 4.
module command_frame_builder_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // payload input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_cmd_id,
    input  logic [7:0]  i_ack_flag,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    // frame output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    output logic        o_run_last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cfb_pkg::*;

    localparam logic REG_HEADER_FIRST  = 1'b0;
    localparam logic REG_HEADER_SECOND = 1'b1;

    logic [7:0]  r_header_first;
    logic [7:0]  r_header_second;

    logic        r_in_valid;
    logic [7:0]  r_cmd_id;
    logic [7:0]  r_ack_flag;
    logic [15:0] r_payload_length;
    logic [7:0]  r_data_byte;

    logic        r_in_frame;
    logic [15:0] r_bytes_left;

    logic        w_free;
    logic        w_load;
    logic        w_in_xfer;
    logic [15:0] w_left_now;
    logic [15:0] n_bytes_left;
    logic        w_close;
    t_load       w_load_data;

    // Configuration registers: write on the access phase, read back always
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_HEADER_FIRST:  prdata = {24'h000000, r_header_first};
            REG_HEADER_SECOND: prdata = {24'h000000, r_header_second};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= '0;
            r_header_second <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_HEADER_FIRST:  r_header_first  <= pwdata[7:0];
                REG_HEADER_SECOND: r_header_second <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    // Input register: hold one item until the result buffer takes it
    assign w_load    = r_in_valid && w_free;
    assign o_stall   = r_in_valid && !w_free;
    assign w_in_xfer = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd_id         <= i_cmd_id;
            r_ack_flag       <= i_ack_flag;
            r_payload_length <= i_payload_length;
            r_data_byte      <= i_data_byte;
        end
    end

    // Frame tracking: a zero length still carries the one data byte
    assign w_left_now   = r_in_frame ? r_bytes_left
                        : ((r_payload_length == 16'h0000) ? 16'h0001 : r_payload_length);
    assign n_bytes_left = w_left_now - 16'h0001;
    assign w_close      = (n_bytes_left == 16'h0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
        end else if (w_load) begin
            r_in_frame   <= !w_close;
            r_bytes_left <= n_bytes_left;
        end
    end

    // Build the buffer load: header plus data on frame start, else data only
    always_comb begin
        w_load_data = '0;
        if (r_in_frame) begin
            w_load_data.bytes[0] = r_data_byte;
            w_load_data.n_data   = CNT_W'(1);
        end else begin
            w_load_data.bytes[0] = r_header_first;
            w_load_data.bytes[1] = r_header_second;
            w_load_data.bytes[2] = r_cmd_id;
            w_load_data.bytes[3] = r_ack_flag;
            w_load_data.bytes[4] = r_payload_length[15:8];
            w_load_data.bytes[5] = r_payload_length[7:0];
            w_load_data.bytes[6] = r_data_byte;
            w_load_data.n_data   = CNT_W'(BUF_DEPTH);
        end
        w_load_data.add_crc = w_close;
    end

    cfb_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_load_data (w_load_data),
        .o_free      (w_free),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_run_last  (o_run_last)
    );

endmodule

// ===== rtl/cfb_checker.sv =====
// ============================================================================
// cfb_checker - port-level checks for the command frame builder
// Watches the top level's ports and flags behavior that breaks its contract.
// ============================================================================
module cfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_frame_end,
    input logic        o_run_last,
    input logic        pready
);

    // A stalled result holds its byte and flags
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte)
                               && $stable(o_frame_end) && $stable(o_run_last))
        else $error("stalled output changed");

    // The CRC high byte always closes its item's run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_run_last)
        else $error("frame end without run last");

    // Input backpressure only while results are pending
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    // Reset leaves both channels empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall && pready)
        else $error("channels not idle after reset");

endmodule

bind command_frame_builder_crc16 cfb_checker u_checker (.*);

// ===== test/command_frame_builder_crc16_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// command_frame_builder_crc16_tb - self-checking bench for the frame builder
// Sends payload bytes framed into commands of random length and content.
// A frame model predicts every header, payload and CRC-16/MODBUS byte, and
// each output transfer is checked against it. The header registers are
// written and read back over the APB port. Both channels idle and stall at
// random, and one long receiver hold-off backs the block up into its input.
// ============================================================================

// One output byte with its flags, as the block sends it
typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       run_last;
} t_frame_byte;

// Frame model and store of the bytes still owed by the block
class FrameScoreboard;
    logic [7:0]  hdr_first  = 8'h00;
    logic [7:0]  hdr_second = 8'h00;
    logic [15:0] crc        = 16'hFFFF;
    bit          frame_open = 1'b0;
    logic [15:0] bytes_due  = 16'h0000;
    t_frame_byte owed_q[$];
    int          errors     = 0;

    task report_mismatch(input string msg);
        if (errors < 50) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        errors++;
    endtask

    // CRC-16/MODBUS update of one byte, LSB first
    function logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    function void owe_byte(input logic [7:0] d, input logic fe, input logic rl,
                           input bit fold);
        t_frame_byte fb;
        fb.data      = d;
        fb.frame_end = fe;
        fb.run_last  = rl;
        owed_q.push_back(fb);
        if (fold) begin
            crc = crc_fold(crc, d);
        end
    endfunction

    // Work out the bytes caused by one accepted payload transfer
    function void note_transfer(input logic [7:0] cmd, input logic [7:0] ack,
                                input logic [15:0] len, input logic [7:0] dat);
        logic [15:0] remaining;
        logic [15:0] crc_out;
        bit          closing;
        if (!frame_open) begin
            remaining = (len == 16'd0) ? 16'd1 : len;
        end else begin
            remaining = bytes_due;
        end
        remaining = remaining - 16'd1;
        closing   = (remaining == 16'd0);

        // open the frame with its header
        if (!frame_open) begin
            crc = 16'hFFFF;
            owe_byte(hdr_first, 1'b0, 1'b0, 1'b1);
            owe_byte(hdr_second, 1'b0, 1'b0, 1'b1);
            owe_byte(cmd, 1'b0, 1'b0, 1'b1);
            owe_byte(ack, 1'b0, 1'b0, 1'b1);
            owe_byte(len[15:8], 1'b0, 1'b0, 1'b1);
            owe_byte(len[7:0], 1'b0, 1'b0, 1'b1);
        end
        owe_byte(dat, 1'b0, !closing, 1'b1);

        // close with the CRC, low byte first
        if (closing) begin
            crc_out = crc;
            owe_byte(crc_out[7:0], 1'b0, 1'b0, 1'b0);
            owe_byte(crc_out[15:8], 1'b1, 1'b1, 1'b0);
            crc        = 16'hFFFF;
            frame_open = 1'b0;
        end else begin
            frame_open = 1'b1;
        end
        bytes_due = remaining;
    endfunction

    // Compare one output transfer with the oldest owed byte
    task check_byte(input logic [7:0] d, input logic fe, input logic rl);
        t_frame_byte fb;
        if (owed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", d));
        end else begin
            fb = owed_q.pop_front();
            if (d !== fb.data) begin
                report_mismatch($sformatf("out_byte %02h, want %02h", d, fb.data));
            end
            if (fe !== fb.frame_end) begin
                report_mismatch($sformatf("frame_end %b, want %b on byte %02h",
                                          fe, fb.frame_end, fb.data));
            end
            if (rl !== fb.run_last) begin
                report_mismatch($sformatf("run_last %b, want %b on byte %02h",
                                          rl, fb.run_last, fb.data));
            end
        end
    endtask

    function int pending();
        return owed_q.size();
    endfunction
endclass

module command_frame_builder_crc16_tb;

    localparam int REG_HEADER_FIRST  = 0;
    localparam int REG_HEADER_SECOND = 1;
    localparam int STUCK_LIMIT       = 3000;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [7:0]  i_cmd_id         = 8'h00;
    logic [7:0]  i_ack_flag       = 8'h00;
    logic [15:0] i_payload_length = 16'h0000;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_frame_end;
    logic        o_run_last;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [2:0]  paddr            = 3'd0;
    logic [31:0] pwdata           = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    FrameScoreboard sb = new;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int stuck_cycles   = 0;

    command_frame_builder_crc16 DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd_id         (i_cmd_id),
        .i_ack_flag       (i_ack_flag),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_frame_end      (o_frame_end),
        .o_run_last       (o_run_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check every output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_byte(o_out_byte, o_frame_end, o_run_last);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One APB transfer; starts and ends at a falling edge with psel held
    task apb_xfer(input bit wr, input int idx, input logic [31:0] wd,
                  output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= 3'(idx * 4);
        pwdata  <= wd;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
    endtask

    // Read a header register back and compare with the model
    task cfg_check(input int idx);
        logic [31:0] rd;
        logic [7:0]  want;
        apb_xfer(1'b0, idx, 32'h0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        want = (idx == REG_HEADER_FIRST) ? sb.hdr_first : sb.hdr_second;
        if (rd !== {24'h0, want}) begin
            sb.report_mismatch($sformatf("register %0d reads %08h, want %02h",
                                         idx, rd, want));
        end
    endtask

    task cfg_write(input int idx, input logic [7:0] val);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, {24'h0, val}, rd);
        if (idx == REG_HEADER_FIRST) begin
            sb.hdr_first = val;
        end else begin
            sb.hdr_second = val;
        end
        cfg_check(idx);
    endtask

    // Offer one payload item until it is taken; starts and ends at a falling edge
    task send_item(input logic [7:0] cmd, input logic [7:0] ack,
                   input logic [15:0] len, input logic [7:0] dat);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_cmd_id         <= cmd;
        i_ack_flag       <= ack;
        i_payload_length <= len;
        i_data_byte      <= dat;
        do @(posedge i_clk); while (o_stall);
        sb.note_transfer(cmd, ack, len, dat);
        @(negedge i_clk);
    endtask

    // Hold the input idle until every owed byte has come out
    task drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Whole frame: header fields on the first item, noise on the rest
    task send_frame(input logic [15:0] len, output int sent);
        logic [7:0] ack;
        int         n;
        ack  = $urandom_range(1) ? 8'($urandom_range(1, 2)) : 8'($urandom);
        n    = (len == 16'd0) ? 1 : int'(len);
        send_item(8'($urandom), ack, len, 8'($urandom));
        for (int k = 1; k < n; k++) begin
            send_item(8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        end
        sent = n;
    endtask

    task run_phase(input int n_items, input int gap_pct, input int stall_pct);
        int sent;
        int total;
        total          = 0;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        while (total < n_items) begin
            send_frame(($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 8)), sent);
            total += sent;
        end
    endtask

    initial begin
        int sent;

        // hold reset, then release it
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        cfg_check(REG_HEADER_FIRST);
        cfg_check(REG_HEADER_SECOND);
        cfg_write(REG_HEADER_FIRST, 8'hFF);
        cfg_write(REG_HEADER_SECOND, 8'h00);

        // directed frames: zero length, extremes, ignored mid-frame fields
        send_item(8'hFF, 8'hFF, 16'h0000, 8'hFF);
        send_item(8'h00, 8'h01, 16'h0001, 8'h00);
        send_item(8'h5A, 8'h02, 16'h0002, 8'h80);
        send_item(8'hFF, 8'hFF, 16'hFFFF, 8'h7F);
        send_item(8'hA5, 8'h01, 16'h0003, 8'h01);
        send_item(8'h00, 8'h00, 16'h0000, 8'hFE);
        send_item(8'hFF, 8'hFF, 16'h0000, 8'h55);

        // register write with a frame open: new headers on the next frame
        send_item(8'h3C, 8'h02, 16'h0003, 8'hAA);
        drain();
        cfg_write(REG_HEADER_FIRST, 8'h00);
        cfg_write(REG_HEADER_SECOND, 8'hFF);
        send_item(8'h12, 8'h34, 16'h5678, 8'h9A);
        send_item(8'hED, 8'hCB, 16'hA987, 8'h65);
        send_item(8'hC3, 8'h01, 16'h0001, 8'hFF);
        drain();

        // sender mostly busy, receiver mostly stalled
        cfg_write(REG_HEADER_FIRST, 8'($urandom));
        cfg_write(REG_HEADER_SECOND, 8'($urandom));
        run_phase(28, 11, 87);
        drain();

        // sender mostly idle, receiver mostly ready
        cfg_write(REG_HEADER_FIRST, 8'($urandom));
        cfg_write(REG_HEADER_SECOND, 8'($urandom));
        run_phase(28, 87, 11);
        drain();

        // no idling; hold the receiver off so the block backs up
        cfg_write(REG_HEADER_FIRST, 8'hFF);
        cfg_write(REG_HEADER_SECOND, 8'hFF);
        hold_left = 80;
        run_phase(28, 0, 0);
        send_frame(16'($urandom_range(10, 16)), sent);
        drain();

        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
